// File: rtl/siph_pkg.sv
// ----------------------------------------------------------------------------
// siph_pkg
// Shared types, constants and the SipRound function for the SipHash core.
// ----------------------------------------------------------------------------
package siph_pkg;

  localparam int unsigned WORD_W          = 64;
  localparam int unsigned COUNT_W         = 4;
  localparam int unsigned LEN_W           = 8;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned MAX_ROUNDS      = 8;
  localparam int unsigned ROUND_CNT_W     = $clog2(MAX_ROUNDS);
  localparam int unsigned COMPRESS_ROUNDS = 2;
  localparam int unsigned FINAL_ROUNDS    = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef logic [3:0][WORD_W-1:0] chain_t;

  // one classified work item for the round engine
  typedef struct packed {
    logic              first;
    logic              do_word;
    logic              do_final;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] tail;
  } op_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned s);
    rotl = (x << s) | (x >> (WORD_W - s));
  endfunction

  function automatic chain_t sip_round(input chain_t v);
    logic [WORD_W-1:0] a, b, c, d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b; b = rotl(b, 13) ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16) ^ c;
    a = a + d; d = rotl(d, 21) ^ a;
    c = c + b; b = rotl(b, 17) ^ c; c = rotl(c, 32);
    sip_round = {d, c, b, a};
  endfunction

endpackage

// File: rtl/siph_if.sv
// ----------------------------------------------------------------------------
// siph_if
// Valid/ready stream interfaces for message words and digests.
// ----------------------------------------------------------------------------
interface siph_in_if;
  logic                                valid;
  logic                                ready;
  logic [siph_pkg::WORD_W-1:0]         data_word;
  logic [siph_pkg::COUNT_W-1:0]        byte_count;
  logic                                last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface siph_out_if;
  logic                        valid;
  logic                        ready;
  logic [siph_pkg::WORD_W-1:0] digest;

  modport source (output valid, digest, input ready);
  modport sink   (input valid, digest, output ready);
endinterface

// File: rtl/siph_front.sv
// ----------------------------------------------------------------------------
// siph_front
// Accepts message words, tracks message start and length, builds the tail.
// ----------------------------------------------------------------------------
module siph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  siph_in_if.sink           msg_i,
  output logic              push_valid_o,
  output siph_pkg::op_t     push_op_o,
  input  logic              push_ready_i
);

  logic                           mid_q, mid_d;
  logic [siph_pkg::LEN_W-1:0]     len_q, len_d;
  logic [siph_pkg::LEN_W-1:0]     len_base;
  logic [siph_pkg::COUNT_W-1:0]   cnt_sat;
  logic [siph_pkg::WORD_W-1:0]    masked;
  logic                           accept;

  assign msg_i.ready  = push_ready_i;
  assign push_valid_o = msg_i.valid;
  assign accept       = msg_i.valid && push_ready_i;

  always_comb begin
    len_base = mid_q ? len_q : '0;
    cnt_sat  = (msg_i.byte_count > siph_pkg::FULL_COUNT) ? siph_pkg::FULL_COUNT
                                                         : msg_i.byte_count;
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = ((b < 32'(cnt_sat)) && (cnt_sat != siph_pkg::FULL_COUNT))
                         ? msg_i.data_word[8*b +: 8] : 8'h00;
    end

    push_op_o.first = !mid_q;
    push_op_o.word  = msg_i.data_word;
    if (msg_i.last) begin
      push_op_o.do_word  = (cnt_sat == siph_pkg::FULL_COUNT);
      push_op_o.do_final = 1'b1;
      len_d              = len_base + siph_pkg::LEN_W'(cnt_sat);
      mid_d              = 1'b0;
    end else begin
      push_op_o.do_word  = 1'b1;
      push_op_o.do_final = 1'b0;
      len_d              = len_base + siph_pkg::LEN_W'(siph_pkg::FULL_COUNT);
      mid_d              = 1'b1;
    end
    push_op_o.tail = {len_d, masked[siph_pkg::WORD_W-siph_pkg::LEN_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
      len_q <= '0;
    end else if (accept) begin
      mid_q <= mid_d;
      len_q <= len_d;
    end
  end

endmodule

// File: rtl/siph_queue.sv
// ----------------------------------------------------------------------------
// siph_queue
// Two-entry queue decoupling the front end from the round engine.
// ----------------------------------------------------------------------------
module siph_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  siph_pkg::op_t     push_op_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output siph_pkg::op_t     pop_op_o,
  input  logic              pop_i
);

  localparam int unsigned PTR_W = $clog2(siph_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(siph_pkg::QUEUE_DEPTH + 1);

  siph_pkg::op_t         entry_q [siph_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      count_q;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(siph_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/siph_back.sv
// ----------------------------------------------------------------------------
// siph_back: round engine that absorbs words, finalises and emits the digest.
// One SipRound per cycle; the last final round waits while the output is full.
// ----------------------------------------------------------------------------
module siph_back #(
  parameter int unsigned COMPRESS_ROUNDS = siph_pkg::COMPRESS_ROUNDS,
  parameter int unsigned FINAL_ROUNDS    = siph_pkg::FINAL_ROUNDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [siph_pkg::WORD_W-1:0] key_low_i,
  input  logic [siph_pkg::WORD_W-1:0] key_high_i,
  input  logic                        op_valid_i,
  input  siph_pkg::op_t               op_i,
  output logic                        pop_o,
  siph_out_if.source                  hash_o
);

  localparam logic [siph_pkg::ROUND_CNT_W-1:0] C_LAST =
    siph_pkg::ROUND_CNT_W'(COMPRESS_ROUNDS - 1);
  localparam logic [siph_pkg::ROUND_CNT_W-1:0] F_LAST =
    siph_pkg::ROUND_CNT_W'(FINAL_ROUNDS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COMP = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  siph_pkg::chain_t                  v_q, v_d, rnd, fin_v, base;
  logic [siph_pkg::WORD_W-1:0]       m_q, m_d, tail_q, tail_d;
  logic                              tail_pend_q, tail_pend_d;
  logic                              fin_pend_q, fin_pend_d;
  logic [siph_pkg::ROUND_CNT_W-1:0]  cnt_q, cnt_d;
  logic                              try_load, out_load, out_free;
  logic                              out_valid_q;
  logic [siph_pkg::WORD_W-1:0]       digest_q;

  assign out_free     = !out_valid_q || hash_o.ready;
  assign hash_o.valid = out_valid_q;
  assign hash_o.digest = digest_q;

  always_comb begin
    rnd         = siph_pkg::sip_round(v_q);
    fin_v       = rnd;
    fin_v[0]    = rnd[0] ^ m_q;
    state_d     = state_q;
    v_d         = v_q;
    m_d         = m_q;
    tail_d      = tail_q;
    tail_pend_d = tail_pend_q;
    fin_pend_d  = fin_pend_q;
    cnt_d       = cnt_q;
    try_load    = 1'b0;
    out_load    = 1'b0;
    pop_o       = 1'b0;
    base        = v_q;

    case (state_q)
      S_IDLE: begin
        try_load = 1'b1;
      end
      S_COMP: begin
        if (cnt_q == '0) begin
          v_d = fin_v;
          if (tail_pend_q) begin
            v_d[3]      = fin_v[3] ^ tail_q;
            m_d         = tail_q;
            tail_pend_d = 1'b0;
            cnt_d       = C_LAST;
          end else if (fin_pend_q) begin
            v_d[2]  = fin_v[2] ^ siph_pkg::FINAL_XOR;
            cnt_d   = F_LAST;
            state_d = S_FIN;
          end else begin
            state_d  = S_IDLE;
            try_load = 1'b1;
          end
        end else begin
          v_d   = rnd;
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        if (cnt_q != '0) begin
          v_d   = rnd;
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (try_load && op_valid_i) begin
      pop_o = 1'b1;
      if (op_i.first) begin
        base = {key_high_i ^ siph_pkg::IV3, key_low_i ^ siph_pkg::IV2,
                key_high_i ^ siph_pkg::IV1, key_low_i ^ siph_pkg::IV0};
      end else begin
        base = v_d;
      end
      if (op_i.do_word) begin
        base[3]     = base[3] ^ op_i.word;
        m_d         = op_i.word;
        tail_pend_d = op_i.do_final;
      end else begin
        base[3]     = base[3] ^ op_i.tail;
        m_d         = op_i.tail;
        tail_pend_d = 1'b0;
      end
      tail_d     = op_i.tail;
      fin_pend_d = op_i.do_final;
      v_d        = base;
      cnt_d      = C_LAST;
      state_d    = S_COMP;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    m_q    <= m_d;
    tail_q <= tail_d;
    if (out_load) begin
      digest_q <= rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tail_pend_q <= 1'b0;
      fin_pend_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_pend_q <= tail_pend_d;
      fin_pend_q  <= fin_pend_d;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (hash_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/siphash_2_4_keyed_hash_core.sv
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash_core
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Words stream back to back: the round engine computes one SipRound per cycle
// while it works, holding its last final round while the digest output is
// full, and loads the next queued word as a word's COMPRESS_ROUNDS rounds
// complete; a word that finds the engine idle is loaded before its first
// round. The tail block gets COMPRESS_ROUNDS rounds, preceded by as many for
// the last word if it carries eight bytes, then FINAL_ROUNDS rounds run before
// the digest is registered, and the engine returns to idle before the next
// message. A two-entry queue keeps the input open while the engine works, and
// the next message may start while the previous digest waits to be taken. The
// key is sampled on the first word of each message; write it between messages.
module siphash_2_4_keyed_hash_core #(
  parameter int unsigned COMPRESS_ROUNDS = siph_pkg::COMPRESS_ROUNDS,
  parameter int unsigned FINAL_ROUNDS    = siph_pkg::FINAL_ROUNDS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [siph_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [siph_pkg::WORD_W-1:0]    cfg_wdata_i,
  siph_in_if.sink                        msg_i,
  siph_out_if.source                     hash_o
);

  logic [siph_pkg::WORD_W-1:0] key_low_q, key_high_q;
  logic                        push_valid, push_ready, pop_valid, pop;
  siph_pkg::op_t               push_op, pop_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        siph_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        siph_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  siph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg_i),
    .push_valid_o (push_valid),
    .push_op_o    (push_op),
    .push_ready_i (push_ready)
  );

  siph_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_op_i    (push_op),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_op_o     (pop_op),
    .pop_i        (pop)
  );

  siph_back #(
    .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
    .FINAL_ROUNDS    (FINAL_ROUNDS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .op_valid_i (pop_valid),
    .op_i       (pop_op),
    .pop_o      (pop),
    .hash_o     (hash_o)
  );

endmodule
